FILE: hdl/ocg_pkg.sv
// shared types and constants for the octree child key generator
package ocg_pkg;

  localparam int KEY_W     = 64;
  localparam int LVL_W     = 5;
  localparam int EXTRA_W   = 2;
  localparam int OFS_W     = 2;
  localparam int CNT_W     = 6;
  localparam int GRP_W     = 3;
  localparam int WIN_W     = KEY_W + 2;
  localparam int SUFFIX_W  = 7;

  localparam logic [LVL_W-1:0]   MAX_LEVEL  = LVL_W'(21);
  localparam logic [LVL_W-1:0]   TOP_GROUP  = LVL_W'(21);
  localparam logic [EXTRA_W-1:0] EXTRA_MAX  = EXTRA_W'(2);
  localparam logic [GRP_W-1:0]   GRP_EMPTY  = GRP_W'(0);
  localparam logic [GRP_W-1:0]   GRP_SENT   = GRP_W'(1);

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT,
    S_ERR
  } state_t;

  // view of the scan unit seen by the sequencer
  typedef struct packed {
    logic [GRP_W-1:0] grp;
    logic [LVL_W-1:0] lvl;
    logic [KEY_W-1:0] mask;
    logic [KEY_W-1:0] base;
  } scan_st_t;

  typedef struct packed {
    logic [KEY_W-1:0] child_id;
    logic [OFS_W-1:0] offset_x;
    logic [OFS_W-1:0] offset_y;
    logic [OFS_W-1:0] offset_z;
    logic [LVL_W-1:0] src_level;
    logic [1:0]       status;
    logic             last;
  } res_t;

endpackage

FILE: hdl/ocg_scan_unit.sv
// group scanner: shifts the key three bits per step to find the sentinel group
module ocg_scan_unit (
  input  logic                     clk,
  input  logic                     load,
  input  logic                     step,
  input  logic [ocg_pkg::KEY_W-1:0] key,
  output ocg_pkg::scan_st_t        st
);
  import ocg_pkg::*;

  logic [WIN_W-1:0] win_r;
  logic [WIN_W-1:0] win_nxt;
  logic [KEY_W-1:0] mask_r;
  logic [KEY_W-1:0] mask_nxt;
  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] key_nxt;
  logic [LVL_W-1:0] lvl_r;
  logic [LVL_W-1:0] lvl_nxt;

  always_comb begin
    win_nxt  = win_r;
    mask_nxt = mask_r;
    key_nxt  = key_r;
    lvl_nxt  = lvl_r;
    if (load) begin
      win_nxt  = {2'b00, key};
      mask_nxt = {1'b1, {(KEY_W-1){1'b0}}};
      key_nxt  = key;
      lvl_nxt  = TOP_GROUP;
    end else if (step) begin
      win_nxt  = win_r << GRP_W;
      mask_nxt = mask_r >> GRP_W;
      lvl_nxt  = lvl_r - LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    mask_r <= mask_nxt;
    key_r  <= key_nxt;
    lvl_r  <= lvl_nxt;
  end

  // once the sentinel group is on top, mask is one-hot at the sentinel bit
  assign st.grp  = win_r[WIN_W-1 -: GRP_W];
  assign st.lvl  = lvl_r;
  assign st.mask = mask_r;
  assign st.base = key_r & ~mask_r;

endmodule

FILE: hdl/ocg_child_gen.sv
// child key former: places offset groups and a new sentinel above the base groups
module ocg_child_gen (
  input  ocg_pkg::scan_st_t           st,
  input  logic [ocg_pkg::EXTRA_W-1:0] extra,
  input  logic [ocg_pkg::CNT_W-1:0]   cnt,
  output ocg_pkg::res_t               res
);
  import ocg_pkg::*;

  logic [OFS_W-1:0]    ox;
  logic [OFS_W-1:0]    oy;
  logic [OFS_W-1:0]    oz;
  logic [SUFFIX_W-1:0] suffix;
  logic [CNT_W-1:0]    cnt_last;
  logic [KEY_W-1:0]    child;

  // k innermost, i outermost; group for offset bit 0 sits just below the sentinel
  always_comb begin
    unique case (extra)
      2'd0: begin
        ox = '0; oy = '0; oz = '0;
        suffix   = SUFFIX_W'(1);
        cnt_last = CNT_W'(0);
      end
      2'd1: begin
        ox = {1'b0, cnt[2]};
        oy = {1'b0, cnt[1]};
        oz = {1'b0, cnt[0]};
        suffix   = SUFFIX_W'({1'b1, cnt[2], cnt[1], cnt[0]});
        cnt_last = CNT_W'(7);
      end
      default: begin
        ox = cnt[5:4];
        oy = cnt[3:2];
        oz = cnt[1:0];
        suffix   = {1'b1, cnt[4], cnt[2], cnt[0], cnt[5], cnt[3], cnt[1]};
        cnt_last = CNT_W'(63);
      end
    endcase
  end

  always_comb begin
    child = st.base;
    for (int t = 0; t < SUFFIX_W; t++) begin
      if (suffix[t]) child = child | (st.mask << t);
    end
  end

  assign res.child_id  = child;
  assign res.offset_x  = ox;
  assign res.offset_y  = oy;
  assign res.offset_z  = oz;
  assign res.src_level = st.lvl;
  assign res.status    = ST_OK;
  assign res.last      = (cnt == cnt_last);

endmodule

FILE: hdl/octree_child_key_generator_top.sv
// octree child key generator: decodes a sentinel-led cell key and emits its refined children
//
// An input key is taken only while the block is idle. A shared three-bit
// group shifter scans the key from the top group down, one group per cycle,
// to locate the sentinel of the key. A key with extra_levels = e then
// yields 8^e children, one per cycle while the output is drained, the last
// one flagged by out_last. A zero key, a sentinel off a group boundary, or
// a refined level above 21 gives one error result instead. The output is
// registered, so the final child waits there while the next key is
// accepted. extra_levels resets to 1 and a write of 3 is stored as 2.
module octree_child_key_generator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ocg_pkg::KEY_W-1:0]     in_subgrid_id,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ocg_pkg::EXTRA_W-1:0]   cfg_extra_levels,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ocg_pkg::KEY_W-1:0]     out_child_id,
  output logic [ocg_pkg::OFS_W-1:0]     out_offset_x,
  output logic [ocg_pkg::OFS_W-1:0]     out_offset_y,
  output logic [ocg_pkg::OFS_W-1:0]     out_offset_z,
  output logic [ocg_pkg::LVL_W-1:0]     out_src_level,
  output logic [1:0]                    out_status,
  output logic                          out_last
);
  import ocg_pkg::*;

  state_t           state_r;
  state_t           state_nxt;
  logic [EXTRA_W-1:0] extra_r;
  logic [EXTRA_W-1:0] extra_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [1:0]       err_status_r;
  logic [1:0]       err_status_nxt;
  logic [LVL_W-1:0] err_level_r;
  logic [LVL_W-1:0] err_level_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  res_t             out_r;
  res_t             out_nxt;

  scan_st_t scan_st;
  res_t     child_res;
  res_t     err_res;
  logic     in_xfer;
  logic     slot_free;
  logic     scan_load;
  logic     scan_step;
  logic     out_load;
  logic     found;
  logic     bad_group;
  logic     zero_key;
  logic     overflow;

  ocg_scan_unit u_scan (
    .clk  (clk),
    .load (scan_load),
    .step (scan_step),
    .key  (in_subgrid_id),
    .st   (scan_st)
  );

  ocg_child_gen u_child (
    .st    (scan_st),
    .extra (extra_r),
    .cnt   (cnt_r),
    .res   (child_res)
  );

  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign found     = (scan_st.grp == GRP_SENT);
  assign bad_group = (scan_st.grp != GRP_EMPTY) && (scan_st.grp != GRP_SENT);
  assign zero_key  = (scan_st.grp == GRP_EMPTY) && (scan_st.lvl == '0);
  assign overflow  = ({1'b0, scan_st.lvl} + (LVL_W+1)'(extra_r)) > (LVL_W+1)'(MAX_LEVEL);

  assign err_res.child_id  = '0;
  assign err_res.offset_x  = '0;
  assign err_res.offset_y  = '0;
  assign err_res.offset_z  = '0;
  assign err_res.src_level = err_level_r;
  assign err_res.status    = err_status_r;
  assign err_res.last      = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_SCAN;
      S_SCAN: begin
        if (found) begin
          state_nxt = overflow ? S_ERR : S_EMIT;
        end else if (bad_group || zero_key) begin
          state_nxt = S_ERR;
        end
      end
      S_EMIT: if (slot_free && child_res.last) state_nxt = S_IDLE;
      S_ERR:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    scan_load = 1'b0;
    scan_step = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        scan_load = in_valid;
      end
      S_SCAN:  scan_step = (scan_st.grp == GRP_EMPTY) && !zero_key;
      S_EMIT:  out_load  = slot_free;
      S_ERR:   out_load  = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    err_status_nxt = err_status_r;
    err_level_nxt  = err_level_r;
    if (in_xfer) cnt_nxt = '0;
    else if (state_r == S_EMIT && out_load) cnt_nxt = cnt_r + CNT_W'(1);
    if (state_r == S_SCAN) begin
      if (found && overflow) begin
        err_status_nxt = ST_OVERFLOW;
        err_level_nxt  = scan_st.lvl;
      end else begin
        err_status_nxt = ST_MALFORMED;
        err_level_nxt  = '0;
      end
    end
  end

  always_comb begin
    extra_nxt = extra_r;
    if (cfg_valid && cfg_ready) begin
      extra_nxt = (cfg_extra_levels > EXTRA_MAX) ? EXTRA_MAX : cfg_extra_levels;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_nxt       = (state_r == S_ERR) ? err_res : child_res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      extra_r     <= EXTRA_W'(1);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      extra_r     <= extra_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_status_r <= err_status_nxt;
    err_level_r  <= err_level_nxt;
    out_r        <= out_nxt;
  end

  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_child_id   = out_r.child_id;
  assign out_offset_x   = out_r.offset_x;
  assign out_offset_y   = out_r.offset_y;
  assign out_offset_z   = out_r.offset_z;
  assign out_src_level  = out_r.src_level;
  assign out_status     = out_r.status;
  assign out_last       = out_r.last;

endmodule

FILE: verif/tb_top.sv
// self-checking testbench for the octree child key generator
module tb_top;
  import ocg_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int RESET_LEN   = 11;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_LEN  = 8;
  localparam int TAIL_LEN    = 40;

  // predicts the children of each accepted key and checks them in order
  class child_scoreboard;
    res_t             expected_children[$];
    logic [1:0]       extra_levels;
    logic [20:0]      coord_x, coord_y, coord_z;
    logic [LVL_W-1:0] level_held;
    int               mismatches;

    function new();
      extra_levels = 2'd1;
      coord_x      = '0;
      coord_y      = '0;
      coord_z      = '0;
      level_held   = '0;
      mismatches   = 0;
    endfunction

    function void load_extra_levels(logic [1:0] v);
      extra_levels = (v > EXTRA_MAX) ? EXTRA_MAX : v;
    endfunction

    function int pending();
      return expected_children.size();
    endfunction

    // group just below the sentinel carries bit 0 of each coordinate
    function logic [KEY_W-1:0] encode_key(logic [20:0] cx, logic [20:0] cy,
                                          logic [20:0] cz, int lev);
      logic [KEY_W-1:0] key;
      key = 64'd1;
      for (int l = 0; l < lev; l++) key = {key[60:0], cx[l], cy[l], cz[l]};
      return key;
    endfunction

    function void push_result(logic [KEY_W-1:0] id, int ox, int oy, int oz,
                              int lvl, logic [1:0] st, logic last);
      res_t r;
      r.child_id  = id;
      r.offset_x  = OFS_W'(ox);
      r.offset_y  = OFS_W'(oy);
      r.offset_z  = OFS_W'(oz);
      r.src_level = LVL_W'(lvl);
      r.status    = st;
      r.last      = last;
      expected_children.push_back(r);
    endfunction

    function void predict_children(logic [KEY_W-1:0] key);
      int          top, lev, total, span;
      logic [2:0]  grp;
      logic [20:0] cx, cy, cz, ox, oy, oz;
      top = -1;
      for (int b = 0; b < KEY_W; b++) if (key[b]) top = b;
      if (top < 0 || top % 3 != 0) begin
        push_result('0, 0, 0, 0, 0, ST_MALFORMED, 1'b1);
        return;
      end
      lev   = top / 3;
      total = lev + extra_levels;
      if (total > MAX_LEVEL) begin
        push_result('0, 0, 0, 0, lev, ST_OVERFLOW, 1'b1);
        return;
      end
      cx = '0;
      cy = '0;
      cz = '0;
      for (int l = 0; l < lev; l++) begin
        grp   = key[3*(lev-1-l) +: 3];
        cx[l] = grp[2];
        cy[l] = grp[1];
        cz[l] = grp[0];
      end
      coord_x    = cx;
      coord_y    = cy;
      coord_z    = cz;
      level_held = LVL_W'(lev);
      span = 1 << extra_levels;
      for (int i = 0; i < span; i++)
        for (int j = 0; j < span; j++)
          for (int k = 0; k < span; k++) begin
            ox = 21'((coord_x << extra_levels) + i);
            oy = 21'((coord_y << extra_levels) + j);
            oz = 21'((coord_z << extra_levels) + k);
            push_result(encode_key(ox, oy, oz, total), i, j, k, level_held, ST_OK,
                        (i == span-1) && (j == span-1) && (k == span-1));
          end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_child(res_t got);
      res_t want;
      if (expected_children.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, child_id=%h",
                                  got.child_id));
        return;
      end
      want = expected_children.pop_front();
      if (got.child_id !== want.child_id)
        report_mismatch($sformatf("child_id %h, want %h", got.child_id, want.child_id));
      if (got.offset_x !== want.offset_x)
        report_mismatch($sformatf("offset_x %0d, want %0d", got.offset_x, want.offset_x));
      if (got.offset_y !== want.offset_y)
        report_mismatch($sformatf("offset_y %0d, want %0d", got.offset_y, want.offset_y));
      if (got.offset_z !== want.offset_z)
        report_mismatch($sformatf("offset_z %0d, want %0d", got.offset_z, want.offset_z));
      if (got.src_level !== want.src_level)
        report_mismatch($sformatf("src_level %0d, want %0d", got.src_level,
                                  want.src_level));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [KEY_W-1:0]     in_subgrid_id;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [EXTRA_W-1:0]   cfg_extra_levels;
  logic                 out_valid;
  logic                 out_ready;
  logic [KEY_W-1:0]     out_child_id;
  logic [OFS_W-1:0]     out_offset_x;
  logic [OFS_W-1:0]     out_offset_y;
  logic [OFS_W-1:0]     out_offset_z;
  logic [LVL_W-1:0]     out_src_level;
  logic [1:0]           out_status;
  logic                 out_last;

  child_scoreboard sb = new();
  int              in_gap_pct;
  int              out_stall_pct;
  int              cycles;

  octree_child_key_generator_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_subgrid_id    (in_subgrid_id),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_extra_levels (cfg_extra_levels),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_child_id     (out_child_id),
    .out_offset_x     (out_offset_x),
    .out_offset_y     (out_offset_y),
    .out_offset_z     (out_offset_z),
    .out_src_level    (out_src_level),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  initial clk = 1'b0;
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= out_stall_pct);

  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_valid && out_ready) begin
      got.child_id  = out_child_id;
      got.offset_x  = out_offset_x;
      got.offset_y  = out_offset_y;
      got.offset_z  = out_offset_z;
      got.src_level = out_src_level;
      got.status    = out_status;
      got.last      = out_last;
      sb.check_child(got);
    end
  end

  task send_key(logic [KEY_W-1:0] key);
    @(negedge clk);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_subgrid_id <= key;
    do @(posedge clk); while (!in_ready);
    sb.predict_children(key);
  endtask

  // drop valid and let every pending child come out
  task drain_children();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_LEN) @(posedge clk);
  endtask

  task write_extra_levels(logic [EXTRA_W-1:0] v);
    @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_extra_levels <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.load_extra_levels(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function logic [KEY_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function logic [KEY_W-1:0] below_bit(int pos);
    return (64'd1 << pos) - 64'd1;
  endfunction

  // mostly well-formed keys with random coordinates, the rest noise
  function logic [KEY_W-1:0] random_key();
    int pick, lev, top;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      lev = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 6) : $urandom_range(0, 21);
      return (64'd1 << (3*lev)) | (rand_word() & below_bit(3*lev));
    end else if (pick < 80) begin
      return rand_word();
    end else if (pick < 92) begin
      do top = $urandom_range(0, 63); while (top % 3 == 0);
      return (64'd1 << top) | (rand_word() & below_bit(top));
    end else if (pick < 96) begin
      return '0;
    end
    return '1;
  endfunction

  initial begin
    int random_cfg [6];
    random_cfg = '{2, 1, 0, 3, 1, 2};
    cycles           = 0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_subgrid_id    = '0;
    cfg_valid        = 1'b0;
    cfg_extra_levels = '0;
    out_ready        = 1'b0;
    in_gap_pct       = 17;
    out_stall_pct    = 57;
    repeat (RESET_LEN) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset depth of one level: zero key, level 0, off-boundary and overflow keys
    send_key(64'h0);
    send_key(64'h1);
    send_key(64'h2);
    send_key(64'h8);
    send_key(64'hF);
    send_key(64'h10);
    send_key(64'h8000_0000_0000_0000);
    send_key(64'h4000_0000_0000_0000);
    send_key((64'd1 << 60) | below_bit(60));
    send_key('1);
    drain_children();

    // no refinement: top level keys pass through
    write_extra_levels(2'd0);
    send_key('1);
    send_key(64'h8000_0000_0000_0000);
    send_key(64'h1);
    send_key(64'h0);
    send_key(64'hA);
    send_key((64'd1 << 60) | (rand_word() & below_bit(60)));
    drain_children();

    // three saturates to two levels
    write_extra_levels(2'd3);
    send_key(64'h1);
    send_key(64'hF);
    send_key((64'd1 << 57) | below_bit(57));
    send_key(64'd1 << 60);
    send_key(64'h20);
    drain_children();

    for (int ph = 0; ph < 6; ph++) begin
      unique case (ph / 2)
        0: begin
          in_gap_pct    = 17;
          out_stall_pct = 57;
        end
        1: begin
          in_gap_pct    = 57;
          out_stall_pct = 17;
        end
        default: begin
          in_gap_pct    = 0;
          out_stall_pct = 0;
        end
      endcase
      write_extra_levels(EXTRA_W'(random_cfg[ph]));
      for (int n = 0; n < 18; n++) send_key(random_key());
      drain_children();
    end

    repeat (TAIL_LEN) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
